[hdl/lzw_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LZW encoder package
// Shared types and constants for the GIF LZW encoder.
// ---------------------------------------------------------------------------
package lzw_pkg;
    localparam logic [11:0] CLEAR_CODE  = 12'd256;
    localparam logic [11:0] END_CODE    = 12'd257;
    localparam logic [12:0] FIRST_FREE  = 13'd258;
    localparam logic [12:0] CODE_LIMIT  = 13'd4096;
    localparam logic [3:0]  START_WIDTH = 4'd9;
    localparam logic [3:0]  MAX_WIDTH   = 4'd12;
    localparam int          OUT_MAX     = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAIN0,
        ST_HASH,
        ST_PROBE,
        ST_CHECK,
        ST_DECIDE,
        ST_WRITE,
        ST_LAST,
        ST_DRAIN1,
        ST_WIPE
    } t_state;

    // dictionary entry: used, tag, code, key
    typedef struct packed {
        logic        used;
        logic [7:0]  tag;
        logic [11:0] code;
        logic [19:0] key;
    } t_entry;

    typedef struct packed {
        logic [7:0] data;
        logic       done;
    } t_beat;
endpackage

[hdl/lzw_stream_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LZW stream interfaces
// Valid/ready channels for pixel input and code byte output.
// ---------------------------------------------------------------------------
interface lzw_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_index;
    logic       frame_end;
    modport source (output valid, output pixel_index, output frame_end, input ready);
    modport sink (input valid, input pixel_index, input frame_end, output ready);
endinterface

interface lzw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       frame_done;
    modport source (output valid, output code_byte, output frame_done, input ready);
    modport sink (input valid, input code_byte, input frame_done, output ready);
endinterface

[hdl/lzw_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LZW generic RAM
// Single-port synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[hdl/lzw_hash.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LZW hash
// Registered multiplicative hash of a 20-bit key to a home slot.
// ---------------------------------------------------------------------------
module lzw_hash import lzw_pkg::*; #(
    parameter int DICT_SLOTS = 8192
) (
    input  logic                          i_clk,
    input  logic [19:0]                   i_key,
    output logic [$clog2(DICT_SLOTS)-1:0] o_slot
);
    localparam int AW = $clog2(DICT_SLOTS);
    logic [31:0] n_prod;

    assign n_prod = i_key * 32'd2654435761;

    // slot count is a power of two: the modulo is a mask
    always_ff @(posedge i_clk) begin
        o_slot <= n_prod[8 +: AW];
    end
endmodule

[hdl/gif_lzw_encoder_core.sv]
`timescale 1ns / 1ps
// Flow: a pixel is taken only while idle; bytes queued by earlier items leave first, then,
//   unless the pixel starts a frame, it is hashed and its probe walks the occupied slots;
//   its own bytes follow, with the closing codes at a frame end. No new pixel is taken
//   until the item is through, and a stalled sink holds the item in its drain phases.
// Reset: synchronous active-low; reset and each generation wrap run a clearing pass through
//   every slot of the dictionary memory, no input taken meanwhile.
// ---------------------------------------------------------------------------
// GIF LZW encoder core
// Streams palette indices into a packed LSB-first GIF LZW code stream.
// ---------------------------------------------------------------------------
module gif_lzw_encoder_core import lzw_pkg::*; #(
    parameter int DICT_SLOTS    = 8192,
    parameter int MAX_CODE_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzw_pix_if.sink    i_pix,
    lzw_byte_if.source o_byte
);
    localparam int AW = $clog2(DICT_SLOTS);
    localparam logic [3:0] MAXW = 4'(MAX_CODE_BITS);

    // ---- encoder state ----
    t_state         r_state, n_state;
    logic [11:0]    r_prefix, n_prefix;
    logic [12:0]    r_next, n_next;
    logic [3:0]     r_width, n_width;
    logic [63:0]    r_acc, n_acc;
    logic [6:0]     r_fill, n_fill;
    logic           r_started, n_started;
    logic [7:0]     r_gen, n_gen;
    logic [3:0]     r_pend, n_pend;       // bytes up to and incl. frame's last
    logic [2:0]     r_cnt, n_cnt;         // bytes sent in this item
    logic [7:0]     r_pix, n_pix;
    logic           r_last, n_last;
    logic [AW-1:0]  r_slot, n_slot;
    logic           r_found, n_found;
    logic [11:0]    r_fcode, n_fcode;
    logic [AW-1:0]  r_wipe, n_wipe;

    // output register
    logic           r_ov, n_ov;
    t_beat          r_ob, n_ob;

    // memory port
    logic           m_we;
    logic [AW-1:0]  m_addr;
    t_entry         m_wdata, m_rdata;
    logic [19:0]    w_key;
    logic [AW-1:0]  w_home;

    assign w_key = {r_prefix, r_pix};

    lzw_hash #(.DICT_SLOTS(DICT_SLOTS)) u_hash (
        .i_clk (i_clk), .i_key (w_key), .o_slot (w_home)
    );

    lzw_ram #(.WIDTH($bits(t_entry)), .DEPTH(DICT_SLOTS)) u_dict (
        .i_clk (i_clk), .i_we (m_we), .i_addr (m_addr),
        .i_wdata (m_wdata), .o_rdata (m_rdata)
    );

    assign i_pix.ready     = (r_state == ST_IDLE);
    assign o_byte.valid      = r_ov;
    assign o_byte.code_byte  = r_ob.data;
    assign o_byte.frame_done = r_ob.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_WIPE;
            r_prefix  <= '0;
            r_next    <= FIRST_FREE;
            r_width   <= START_WIDTH;
            r_acc     <= '0;
            r_fill    <= '0;
            r_started <= 1'b0;
            r_gen     <= '0;
            r_pend    <= '0;
            r_cnt     <= '0;
            r_ov      <= 1'b0;
            r_wipe    <= '0;
        end else begin
            r_state   <= n_state;
            r_prefix  <= n_prefix;
            r_next    <= n_next;
            r_width   <= n_width;
            r_acc     <= n_acc;
            r_fill    <= n_fill;
            r_started <= n_started;
            r_gen     <= n_gen;
            r_pend    <= n_pend;
            r_cnt     <= n_cnt;
            r_ov      <= n_ov;
            r_wipe    <= n_wipe;
        end
        r_pix   <= n_pix;
        r_last  <= n_last;
        r_slot  <= n_slot;
        r_found <= n_found;
        r_fcode <= n_fcode;
        r_ob    <= n_ob;
    end

    // Append a code to the bit queue at current fill.
    function automatic logic [63:0] put_bits(input logic [63:0] acc, input logic [6:0] fill,
                                             input logic [11:0] code, input logic [3:0] w);
        logic [63:0] v;
        v = 64'(code & 12'((13'd1 << w) - 13'd1));
        return acc | (v << fill[5:0]);
    endfunction

    logic w_can_emit;
    logic w_live;
    logic w_oslot;

    assign w_live  = m_rdata.used && (m_rdata.tag == r_gen);
    assign w_oslot = !r_ov || o_byte.ready;
    assign w_can_emit = w_oslot && (r_fill >= 7'd8) && (r_cnt < 3'(OUT_MAX));

    always_comb begin
        n_state   = r_state;
        n_prefix  = r_prefix;
        n_next    = r_next;
        n_width   = r_width;
        n_acc     = r_acc;
        n_fill    = r_fill;
        n_started = r_started;
        n_gen     = r_gen;
        n_pend    = r_pend;
        n_cnt     = r_cnt;
        n_pix     = r_pix;
        n_last    = r_last;
        n_slot    = r_slot;
        n_found   = r_found;
        n_fcode   = r_fcode;
        n_wipe    = r_wipe;
        n_ov      = r_ov && !o_byte.ready;
        n_ob      = r_ob;
        m_we      = 1'b0;
        m_addr    = r_slot;
        m_wdata   = '0;

        case (r_state)
            ST_WIPE: begin
                m_we   = 1'b1;
                m_addr = r_wipe;
                n_wipe = r_wipe + AW'(1);
                if (r_wipe == AW'(DICT_SLOTS - 1)) begin
                    // pass after reset ends idle; a pass after a wrap resumes its item
                    if (!r_started) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = r_last ? ST_LAST : ST_DRAIN1;
                    end
                end
            end
            ST_IDLE: begin
                if (i_pix.valid) begin
                    n_pix   = i_pix.pixel_index;
                    n_last  = i_pix.frame_end;
                    n_cnt   = '0;
                    n_state = ST_DRAIN0;
                end
            end
            ST_DRAIN0, ST_DRAIN1, ST_LAST: begin
                // byte emission shared by pre- and post-drain phases; LAST also queues the closing codes
                if (r_state == ST_LAST) begin
                    n_acc  = put_bits(r_acc, r_fill, r_prefix, r_width);
                    n_acc  = put_bits(n_acc, r_fill + 7'(r_width), END_CODE, r_width);
                    n_fill = (r_fill + 7'({r_width, 1'b0}) + 7'd7) & 7'h78;
                    n_pend = n_fill[6:3];
                    n_started = 1'b0;
                    n_state = ST_DRAIN1;
                end else if (w_can_emit) begin
                    n_ov      = 1'b1;
                    n_ob.data = r_acc[7:0];
                    n_ob.done = (r_pend == 4'd1);
                    if (r_pend != 4'd0) begin
                        n_pend = r_pend - 4'd1;
                    end
                    n_acc  = r_acc >> 8;
                    n_fill = r_fill - 7'd8;
                    n_cnt  = r_cnt + 3'd1;
                end else if (r_fill < 7'd8 || r_cnt == 3'(OUT_MAX)) begin
                    if (r_state == ST_DRAIN1) begin
                        n_state = ST_IDLE;
                    end else if (!r_started) begin
                        // frame start: new table, clear code at start width
                        n_gen    = r_gen + 8'd1;
                        n_width  = START_WIDTH;
                        n_next   = FIRST_FREE;
                        n_acc    = put_bits(r_acc, r_fill, CLEAR_CODE, START_WIDTH);
                        n_fill   = r_fill + 7'(START_WIDTH);
                        n_prefix = {4'd0, r_pix};
                        n_started = 1'b1;
                        n_state  = r_last ? ST_LAST : ST_DRAIN1;
                        if (n_gen == 8'd0) begin
                            n_wipe  = '0;
                            n_state = ST_WIPE;
                        end
                    end else begin
                        n_state = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                // hash register loads this cycle
                n_state = ST_PROBE;
            end
            ST_PROBE: begin
                if (r_state == ST_PROBE && r_found) begin
                    m_addr = r_slot;
                end
                n_slot  = w_home;
                m_addr  = w_home;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                // read data for r_slot valid this cycle
                if (!w_live) begin
                    n_found = 1'b0;
                    n_state = ST_DECIDE;
                end else if (m_rdata.key == w_key) begin
                    n_found = 1'b1;
                    n_fcode = m_rdata.code;
                    n_state = ST_DECIDE;
                end else begin
                    n_slot  = r_slot + AW'(1);
                    m_addr  = r_slot + AW'(1);
                    n_state = ST_WRITE;   // wait state for the read
                end
            end
            ST_WRITE: begin
                n_state = ST_CHECK;
            end
            ST_DECIDE: begin
                if (r_found) begin
                    n_prefix = r_fcode;
                end else begin
                    n_acc  = put_bits(r_acc, r_fill, r_prefix, r_width);
                    n_fill = r_fill + 7'(r_width);
                    if (r_next < CODE_LIMIT) begin
                        m_we    = 1'b1;
                        m_addr  = r_slot;
                        m_wdata = '{used: 1'b1, tag: r_gen, code: r_next[11:0], key: w_key};
                        n_next  = r_next + 13'd1;
                        if (n_next > (13'd1 << r_width) && r_width < MAXW) begin
                            n_width = r_width + 4'd1;
                        end
                    end else begin
                        n_acc  = put_bits(n_acc, n_fill, CLEAR_CODE, r_width);
                        n_fill = n_fill + 7'(r_width);
                        n_gen  = r_gen + 8'd1;
                        n_width = START_WIDTH;
                        n_next  = FIRST_FREE;
                    end
                    n_prefix = {4'd0, r_pix};
                end
                n_state = r_last ? ST_LAST : ST_DRAIN1;
                if (!r_found && r_next >= CODE_LIMIT && n_gen == 8'd0) begin
                    n_wipe  = '0;
                    n_state = ST_WIPE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // WIPE after a generation wrap picks the item up again at its frame end
    // or its closing drain, so the item's bytes leave as usual.
    // ---- checks ----
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 7'd64) else $error("bit queue overflow");
    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_width >= START_WIDTH) && (r_width <= MAXW)) else $error("code width range");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> (r_state == ST_DRAIN0))
        else $error("accept without drain");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_byte.ready) |=> (r_ov && $stable(r_ob))) else $error("out beat dropped");
endmodule

[sim/gif_lzw_encoder_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// GIF LZW encoder core testbench
// Streams pixel frames into the encoder and compares every code byte with
// an in-bench LZW packer, under several patterns of source and sink idling.
// ---------------------------------------------------------------------------
module gif_lzw_encoder_core_tb;
    import lzw_pkg::*;

    localparam int SLOTS     = 8192;
    localparam int MAX_BITS  = 12;
    localparam int CYC_LIMIT = 3000000;

    logic i_clk;
    logic i_rst_n;

    lzw_pix_if  pix_ch ();
    lzw_byte_if byte_ch ();

    gif_lzw_encoder_core #(.DICT_SLOTS(SLOTS), .MAX_CODE_BITS(MAX_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch.sink),
        .o_byte  (byte_ch.source)
    );

    // ---------------------------------------------------------------------
    // Encoder state mirror: dictionary kept as an associative map per
    // generation; a new table simply empties it.
    // ---------------------------------------------------------------------
    logic [11:0] enc_prefix;
    logic [12:0] enc_next;
    logic [3:0]  enc_width;
    logic [63:0] enc_acc;
    int          enc_fill;
    bit          enc_started;
    int          enc_done_left;
    logic [11:0] enc_dict [int];

    t_beat byte_q [$];

    int   err_cnt;
    int   beat_cnt;
    int   frame_cnt;
    int   pix_cnt;
    int   cyc;
    int   src_idle_pct;
    int   snk_idle_pct;
    bit   snk_hold;

    task automatic enc_reset();
        enc_dict.delete();
        enc_prefix    = '0;
        enc_next      = FIRST_FREE;
        enc_width     = START_WIDTH;
        enc_acc       = '0;
        enc_fill      = 0;
        enc_started   = 0;
        enc_done_left = 0;
    endtask

    task automatic enc_new_table();
        enc_dict.delete();
        enc_width = START_WIDTH;
        enc_next  = FIRST_FREE;
    endtask

    task automatic enc_put(input logic [11:0] code);
        logic [63:0] v;
        v = 64'(code) & ((64'd1 << enc_width) - 1);
        enc_acc  |= v << enc_fill;
        enc_fill += enc_width;
    endtask

    task automatic enc_emit(inout int n);
        t_beat b;
        while (enc_fill >= 8 && n < OUT_MAX) begin
            b.done = 1'b0;
            if (enc_done_left != 0) begin
                if (enc_done_left == 1) b.done = 1'b1;
                enc_done_left--;
            end
            b.data = enc_acc[7:0];
            byte_q = {byte_q, b};
            enc_acc  = enc_acc >> 8;
            enc_fill -= 8;
            n++;
        end
    endtask

    // Expected bytes for one accepted pixel.
    task automatic lzw_predict(input logic [7:0] pix, input bit last);
        int n;
        int key;
        n = 0;
        enc_emit(n);
        if (!enc_started) begin
            enc_new_table();
            enc_put(CLEAR_CODE);
            enc_prefix  = {4'd0, pix};
            enc_started = 1;
        end else begin
            key = {enc_prefix, pix};
            if (enc_dict.exists(key)) begin
                enc_prefix = enc_dict[key];
            end else begin
                enc_put(enc_prefix);
                if (enc_next < CODE_LIMIT) begin
                    enc_dict[key] = enc_next[11:0];
                    enc_next++;
                    if (enc_next > (13'd1 << enc_width) && enc_width < MAX_WIDTH)
                        enc_width++;
                end else begin
                    enc_put(CLEAR_CODE);
                    enc_new_table();
                end
                enc_prefix = {4'd0, pix};
            end
        end
        if (last) begin
            enc_put(enc_prefix);
            enc_put(END_CODE);
            enc_fill      = (enc_fill + 7) & ~7;
            enc_done_left = enc_fill / 8;
            enc_started   = 0;
        end
        enc_emit(n);
    endtask

    // ---------------------------------------------------------------------
    // Clock, cycle limit
    // ---------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc > CYC_LIMIT) begin
                $display("timeout at cycle %0d, %0d bytes pending", cyc, byte_q.size());
                $display("gif_lzw_encoder_core_tb: errors");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sink: random ready, forced low while a long hold is active
    // ---------------------------------------------------------------------
    initial begin
        byte_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            byte_ch.ready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Byte checker
    initial begin
        t_beat exp_b;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
                beat_cnt++;
                if (byte_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected beat data %02h done %0b", $time,
                             byte_ch.code_byte, byte_ch.frame_done);
                end else begin
                    exp_b = byte_q.pop_front();
                    if (exp_b.data !== byte_ch.code_byte) begin
                        err_cnt++;
                        $display("%0t: code_byte expected %02h actual %02h", $time,
                                 exp_b.data, byte_ch.code_byte);
                    end
                    if (exp_b.done !== byte_ch.frame_done) begin
                        err_cnt++;
                        $display("%0t: frame_done expected %0b actual %0b", $time,
                                 exp_b.done, byte_ch.frame_done);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Source side: valid stays up from beat to beat, dropped only for idle
    // cycles or by src_stop
    // ---------------------------------------------------------------------
    task automatic send_pixel(input logic [7:0] pix, input bit last);
        if ($urandom_range(99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_index <= pix;
        pix_ch.frame_end   <= last;
        do @(posedge i_clk); while (!pix_ch.ready);
        lzw_predict(pix, last);
        pix_cnt++;
        if (last) frame_cnt++;
    endtask

    task automatic src_stop();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Frame of len pixels; alpha bounds the palette range to shape repeats.
    task automatic send_frame(input int len, input int alpha);
        for (int k = 0; k < len; k++)
            send_pixel(8'($urandom_range(alpha - 1)), k == len - 1);
    endtask

    task automatic test_directed();
        send_pixel(8'h00, 1'b1);           // single pixel frame
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'hA5, 1'b0);           // repeated runs hit the dictionary
        for (int k = 0; k < 10; k++) send_pixel(8'hA5, 1'b0);
        send_pixel(8'h5A, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b1);
        src_stop();
        wait_drained();
    endtask

    // One long frame of random pixels: enough new pairs to widen codes to 10 bits.
    task automatic test_wide_codes();
        for (int k = 0; k < 300; k++)
            send_pixel(8'($urandom_range(255)), 1'b0);
        send_pixel(8'h3C, 1'b1);
        src_stop();
        wait_drained();
    endtask

    task automatic test_random(input int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(120, 40)
                                           : $urandom_range(12, 1);
            send_frame(len, ($urandom_range(1) == 0) ? 4 : 256);
            sent += len;
        end
    endtask

    // Sink held off long while a frame of 40 pixels keeps coming; then source waits for drain.
    task automatic test_backpressure();
        snk_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                snk_hold = 1'b0;
            end
            begin
                send_frame(40, 256);
                src_stop();
            end
        join
        wait_drained();
    endtask

    initial begin
        err_cnt = 0; beat_cnt = 0; frame_cnt = 0; pix_cnt = 0;
        src_idle_pct = 0; snk_idle_pct = 0; snk_hold = 1'b0;
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_index = '0;
        pix_ch.frame_end   = 1'b0;
        enc_reset();
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        src_idle_pct = 0;  snk_idle_pct = 0;  test_random(50);
        src_idle_pct = 72; snk_idle_pct = 0;  test_random(40);
        src_idle_pct = 0;  snk_idle_pct = 72; test_random(40);
        src_idle_pct = 30; snk_idle_pct = 30; test_random(40);
        test_backpressure();
        src_idle_pct = 0;  snk_idle_pct = 0;  test_wide_codes();

        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("covered %0d pixels in %0d frames, %0d code bytes checked",
                 pix_cnt, frame_cnt, beat_cnt);
        $display("incl. single-pixel frames, code width growth, long sink stall");
        if (err_cnt == 0 && byte_q.size() == 0)
            $display("gif_lzw_encoder_core_tb: clean");
        else
            $display("gif_lzw_encoder_core_tb: errors");
        $finish;
    end
endmodule

[filelist.f]
hdl/lzw_pkg.sv
hdl/lzw_stream_if.sv
hdl/lzw_ram.sv
hdl/lzw_hash.sv
hdl/gif_lzw_encoder_core.sv
sim/gif_lzw_encoder_core_tb.sv
